// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/uule_pkg.sv
// ----------------------------------------------------------------------------
// uule_pkg
// Types, constants and helper functions shared by the uuencode line encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

	// Bytes in one full encoded line.
	localparam int LINE_BYTES = 45;
	// Width of the byte counter, which must hold LINE_BYTES itself.
	localparam int CNT_W = $clog2(LINE_BYTES + 1);
	// Width of a line buffer address.
	localparam int ADDR_W = $clog2(LINE_BYTES);

	// Fixed characters.
	localparam logic [6:0] CHAR_NEWLINE = 7'd10;
	localparam logic [6:0] CHAR_GRAVE = 7'd96;
	localparam logic [6:0] CHAR_SPACE = 7'd32;

	// One input request.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} uule_in_t;

	// One output request.
	typedef struct packed {
		logic [6:0] out_char;
		logic       run_last;
	} uule_out_t;

	// Source of the character loaded into the output register.
	typedef enum logic [2:0] {
		CH_LEN,
		CH_C0,
		CH_C1,
		CH_C2,
		CH_C3,
		CH_NEWLINE,
		CH_GRAVE
	} uule_char_sel_t;

	// Read address offset within the current group of three bytes.
	typedef enum logic [1:0] {
		RD_OFF0,
		RD_OFF1,
		RD_OFF2
	} uule_rd_off_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_C0,
		S_C1,
		S_C2,
		S_C3,
		S_NL,
		S_TERM_GRAVE,
		S_TERM_NL
	} uule_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic           store;
		logic           clr_count;
		logic           clr_ptr;
		logic           adv_ptr;
		uule_rd_off_t   rd_off;
		logic           cap_b1;
		logic           cap_b2;
		logic           cap_b3;
		logic           emit;
		uule_char_sel_t char_sel;
		logic           run_last;
	} uule_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic slot_free;
		logic closes_line;
		logic more_groups;
		logic last;
	} uule_status_t;

	// Map a 6-bit value to its printable character, zero going to grave accent.
	function automatic logic [6:0] enc_char(input logic [5:0] v);
		logic [6:0] c;
		c = {1'b0, v} + CHAR_SPACE;
		return (c == CHAR_SPACE) ? CHAR_GRAVE : c;
	endfunction

endpackage

// File: src/uule_datapath.sv
// ----------------------------------------------------------------------------
// uule_datapath
// Line buffer memory, byte and group counters, group byte registers,
// character encoding and the output register.
// ----------------------------------------------------------------------------
module uule_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uule_pkg::uule_in_t    in_item,
	input  uule_pkg::uule_cmd_t   cmd,
	output uule_pkg::uule_status_t status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output uule_pkg::uule_out_t   out_item
);
	import uule_pkg::*;

	logic [7:0]        mem [LINE_BYTES];
	logic [7:0]        rd_data_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              last_q;
	logic [7:0]        b1_q;
	logic [7:0]        b2_q;
	logic [7:0]        b3_q;
	logic              out_valid_q;
	uule_out_t         out_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [CNT_W:0]    count_inc;
	logic [CNT_W:0]    ptr_ext;
	logic [6:0]        next_char;
	logic              slot_free;

	assign ptr_ext = (CNT_W + 1)'(ptr_q);
	assign count_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
	assign slot_free = !out_valid_q || out_ready;

	// Read address for the byte of the current group selected by the controller.
	always_comb begin
		unique case (cmd.rd_off)
			RD_OFF0: rd_addr = ptr_q;
			RD_OFF1: rd_addr = ptr_q + ADDR_W'(1);
			RD_OFF2: rd_addr = ptr_q + ADDR_W'(2);
			default: rd_addr = ptr_q;
		endcase
	end

	// Line buffer: one write port for incoming bytes, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[count_q[ADDR_W-1:0]] <= in_item.data_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Group byte registers; bytes past the line length read as zero padding.
	always_ff @(posedge clk) begin
		if (cmd.cap_b1) begin
			b1_q <= rd_data_q;
		end
		if (cmd.cap_b2) begin
			b2_q <= (ptr_ext + (CNT_W + 1)'(1) < {1'b0, count_q}) ? rd_data_q : 8'd0;
		end
		if (cmd.cap_b3) begin
			b3_q <= (ptr_ext + (CNT_W + 1)'(2) < {1'b0, count_q}) ? rd_data_q : 8'd0;
		end
	end

	// Byte count, group pointer and end-of-data flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.store) begin
				count_q <= count_inc[CNT_W-1:0];
			end
			if (cmd.store) begin
				last_q <= in_item.end_of_data;
			end
			if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.adv_ptr) begin
				ptr_q <= ptr_q + ADDR_W'(3);
			end
		end
	end

	// Character selection and encoding.
	always_comb begin
		unique case (cmd.char_sel)
			CH_LEN:     next_char = enc_char(6'(count_q));
			CH_C0:      next_char = enc_char(b1_q[7:2]);
			CH_C1:      next_char = enc_char({b1_q[1:0], b2_q[7:4]});
			CH_C2:      next_char = enc_char({b2_q[3:0], b3_q[7:6]});
			CH_C3:      next_char = enc_char(b3_q[5:0]);
			CH_NEWLINE: next_char = CHAR_NEWLINE;
			CH_GRAVE:   next_char = CHAR_GRAVE;
			default:    next_char = CHAR_NEWLINE;
		endcase
	end

	// Output register: loads when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && slot_free) begin
			out_q.out_char <= next_char;
			out_q.run_last <= cmd.run_last;
		end
	end

	// Status to the controller.
	always_comb begin
		status.slot_free = slot_free;
		status.closes_line = (count_inc >= (CNT_W + 1)'(LINE_BYTES)) || in_item.end_of_data;
		status.more_groups = (ptr_ext + (CNT_W + 1)'(3)) < {1'b0, count_q};
		status.last = last_q;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// File: src/uule_controller.sv
// ----------------------------------------------------------------------------
// uule_controller
// State machine that stores incoming bytes and sequences the emission of
// one encoded line and, at end of data, the terminating line.
// ----------------------------------------------------------------------------
module uule_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  uule_pkg::uule_status_t status,
	output uule_pkg::uule_cmd_t    cmd
);
	import uule_pkg::*;

	uule_state_t state_q;
	uule_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.rd_off = RD_OFF0;
		cmd.char_sel = CH_NEWLINE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					if (status.closes_line) begin
						state_next = S_LEN;
					end
				end
			end
			S_LEN: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_LEN;
				cmd.clr_ptr = 1'b1;
				if (status.slot_free) begin
					state_next = S_RD0;
				end
			end
			S_RD0: begin
				cmd.rd_off = RD_OFF0;
				state_next = S_RD1;
			end
			S_RD1: begin
				cmd.cap_b1 = 1'b1;
				cmd.rd_off = RD_OFF1;
				state_next = S_RD2;
			end
			S_RD2: begin
				cmd.cap_b2 = 1'b1;
				cmd.rd_off = RD_OFF2;
				state_next = S_RD3;
			end
			S_RD3: begin
				cmd.cap_b3 = 1'b1;
				state_next = S_C0;
			end
			S_C0: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_C0;
				if (status.slot_free) begin
					state_next = S_C1;
				end
			end
			S_C1: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_C1;
				if (status.slot_free) begin
					state_next = S_C2;
				end
			end
			S_C2: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_C2;
				if (status.slot_free) begin
					state_next = S_C3;
				end
			end
			S_C3: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_C3;
				if (status.slot_free) begin
					cmd.adv_ptr = 1'b1;
					state_next = status.more_groups ? S_RD0 : S_NL;
				end
			end
			S_NL: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_NEWLINE;
				cmd.run_last = !status.last;
				if (status.slot_free) begin
					cmd.clr_count = 1'b1;
					state_next = status.last ? S_TERM_GRAVE : S_IDLE;
				end
			end
			S_TERM_GRAVE: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_GRAVE;
				if (status.slot_free) begin
					state_next = S_TERM_NL;
				end
			end
			S_TERM_NL: begin
				cmd.emit = 1'b1;
				cmd.char_sel = CH_NEWLINE;
				cmd.run_last = 1'b1;
				if (status.slot_free) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/uuencode_line_encoder.sv
// Order: a closing byte moves the controller to S_LEN, which emits the length character.
// Throughput: one byte per cycle while a line fills; then, per three-byte group, S_RD0 to
// S_RD3 make three buffer reads, S_C0 to S_C3 emit four characters, and S_NL ends the line.
// A full 45-byte line thus emits 62 characters; no byte is taken until S_IDLE again.
// Reset: arst_n clears the controller, byte count and output valid; the buffer is not cleared.
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Collects raw bytes into lines and emits each line uuencoded, one character
// per output request, with the terminating line at end of data.
// ----------------------------------------------------------------------------
module uuencode_line_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  uule_pkg::uule_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output uule_pkg::uule_out_t out_item
);
	import uule_pkg::*;

	uule_cmd_t    cmd;
	uule_status_t status;

	// Sequencing.
	uule_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage, encoding and output register.
	uule_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: src/uule_checker.sv
// ----------------------------------------------------------------------------
// uule_checker
// Port-level checks on the uuencode line encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uule_port_checks (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input uule_pkg::uule_in_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input uule_pkg::uule_out_t out_item
);
	import uule_pkg::*;

	logic char_ok;

	// A character is a newline or lies between the first printable one and the grave accent.
	assign char_ok = (out_item.out_char == CHAR_NEWLINE) ||
		((out_item.out_char > CHAR_SPACE) && (out_item.out_char <= CHAR_GRAVE));

	// A stalled output request holds its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

	// Every character is a newline or a printable uuencode character.
	`ASSERT_IMPL(a_char_range, clk, arst_n, out_valid, char_ok)

	// The last character caused by an input always ends a line.
	`ASSERT_IMPL(a_last_newline, clk, arst_n, out_valid && out_item.run_last, out_item.out_char == CHAR_NEWLINE)

	// A byte that ends the data starts emission, so no further byte is taken at once.
	`ASSERT_NEXT(a_eod_blocks, clk, arst_n, in_valid && in_ready && in_item.end_of_data, !in_ready)

endmodule

bind uuencode_line_encoder uule_port_checks u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// File: tb/uule_checker.sv
// ----------------------------------------------------------------------------
// uule_checker
// Watches both request channels of the uuencode line encoder. Every accepted
// input byte is run through a behavioral encoder, and the characters it should
// produce are queued. Every accepted output character is compared, field by
// field, with the oldest queued character.
// ----------------------------------------------------------------------------
module uule_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  uule_pkg::uule_in_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  uule_pkg::uule_out_t out_item,
	output int                  fail_count,
	output int                  pending,
	output int                  chars_checked,
	output int                  lines_predicted
);
	import uule_pkg::*;

	// Mismatch lines beyond this many are counted but not printed.
	localparam int PRINT_LIMIT = 100;

	// Bytes of the line being collected, and how many are held.
	logic [7:0] line_store [LINE_BYTES];
	int         line_fill;

	// Characters still owed by the encoder, oldest first.
	uule_out_t  expected_chars [$];

	initial begin
		fail_count = 0;
		pending = 0;
		chars_checked = 0;
		lines_predicted = 0;
		line_fill = 0;
	end

	// A 6-bit value is sent as value plus 32, with zero sent as a grave accent.
	function automatic logic [6:0] sixbit_char(input logic [5:0] v);
		if (v == 6'd0) begin
			return CHAR_GRAVE;
		end
		return {1'b0, v} + CHAR_SPACE;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task automatic push_char(input logic [6:0] ch);
		uule_out_t c;
		c.out_char = ch;
		c.run_last = 1'b0;
		expected_chars.push_back(c);
	endtask

	// Store one byte and queue every character it causes.
	task automatic encode_byte(input uule_in_t req);
		int         first;
		int         last_idx;
		int         i;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		uule_out_t  tail;
		first = expected_chars.size();
		line_store[line_fill] = req.data_byte;
		line_fill++;

		// A full line, or the end of the data, sends the collected line.
		if (line_fill == LINE_BYTES || req.end_of_data) begin
			push_char(sixbit_char(line_fill[5:0]));
			for (i = 0; i < line_fill; i += 3) begin
				b1 = line_store[i];
				b2 = (i + 1 < line_fill) ? line_store[i + 1] : 8'h00;
				b3 = (i + 2 < line_fill) ? line_store[i + 2] : 8'h00;
				push_char(sixbit_char(b1[7:2]));
				push_char(sixbit_char({b1[1:0], b2[7:4]}));
				push_char(sixbit_char({b2[3:0], b3[7:6]}));
				push_char(sixbit_char(b3[5:0]));
			end
			push_char(CHAR_NEWLINE);
			line_fill = 0;
			lines_predicted++;
		end

		// End of data is followed by the terminating line.
		if (req.end_of_data) begin
			push_char(CHAR_GRAVE);
			push_char(CHAR_NEWLINE);
		end

		// The last character caused by this byte carries the run marker.
		if (expected_chars.size() > first) begin
			last_idx = expected_chars.size() - 1;
			tail = expected_chars[last_idx];
			tail.run_last = 1'b1;
			expected_chars[last_idx] = tail;
		end
	endtask

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin : watch_channels
		uule_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %0d arrived with none expected",
						out_item.out_char));
				end else begin
					want = expected_chars.pop_front();
					chars_checked++;
					if (out_item.out_char !== want.out_char) begin
						report_mismatch($sformatf("char #%0d: out_char %0d, expected %0d",
							chars_checked, out_item.out_char, want.out_char));
					end
					if (out_item.run_last !== want.run_last) begin
						report_mismatch($sformatf("char #%0d: run_last %0b, expected %0b",
							chars_checked, out_item.run_last, want.run_last));
					end
				end
			end
			if (in_valid && in_ready) begin
				encode_byte(in_item);
			end
			pending <= expected_chars.size();
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte requests into the uuencode line encoder and pulls the encoded
// characters out, with random gaps on the input side and random stalls on
// the output side. A short directed run covers padded groups and extreme
// byte values; random messages of mixed length follow, including ones that
// end exactly on a full line and ones that span two lines.
// ----------------------------------------------------------------------------
module testbench;
	import uule_pkg::*;

	// A one-byte message owes eight characters; even with every one stalled, this limit is far
	// above what the run needs.
	localparam int CYCLE_LIMIT = 500000;
	// Stimulus stops once this many bytes have gone in.
	localparam int TOTAL_ITEMS = 200;
	// Past this many bytes neither side idles any more.
	localparam int QUIET_AFTER = 170;
	// Cycles allowed for the encoder to settle at the end.
	localparam int SETTLE_CYCLES = 20;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	uule_in_t  in_item;
	logic      out_valid;
	logic      out_ready;
	uule_out_t out_item;

	int fail_count;
	int pending;
	int chars_checked;
	int lines_predicted;

	int cycle_count = 0;
	int items_sent;
	int messages_sent;
	int msg_len;
	int stall_left;
	bit quiet;
	bit tx_gaps;
	bit rx_gaps;

	uuencode_line_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	uule_checker line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.fail_count      (fail_count),
		.pending         (pending),
		.chars_checked   (chars_checked),
		.lines_predicted (lines_predicted)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Hard limit on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d characters outstanding",
				cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output side: random stalls while output gaps are enabled and the run is not quiet.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && rx_gaps && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one byte and hold it until the encoder takes it.
	task automatic send_byte(input logic [7:0] value, input logic eod);
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= '{data_byte: value, end_of_data: eod};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Leave the input idle for the given number of cycles.
	task automatic hold_off(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending until every owed character has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Random byte, leaning toward all zeros and all ones now and then.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		stall_left = 0;
		quiet = 1'b0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		items_sent = 0;
		messages_sent = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: one, two, three, four and five byte messages, so the last
		// group is padded by two bytes, by one byte, and not at all.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFD, 1'b1);
		messages_sent = 5;
		drain_results();

		// Random messages; the first ends exactly on a full line.
		msg_len = LINE_BYTES;
		while (items_sent < TOTAL_ITEMS) begin
			// The last message is cut short so the byte total stays on target.
			if (msg_len > TOTAL_ITEMS - items_sent) begin
				msg_len = TOTAL_ITEMS - items_sent;
			end
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			for (int k = 1; k <= msg_len; k++) begin
				quiet = (items_sent >= QUIET_AFTER);
				if (!quiet && tx_gaps && $urandom_range(0, 4) == 0) begin
					hold_off($urandom_range(1, 3));
				end
				send_byte(pick_byte(), k == msg_len);
			end
			messages_sent++;
			if (messages_sent == 8) begin
				drain_results();
			end
			case ($urandom_range(0, 7))
				0: begin
					msg_len = LINE_BYTES;
				end
				1: begin
					msg_len = $urandom_range(LINE_BYTES + 1, 2 * LINE_BYTES);
				end
				default: begin
					msg_len = $urandom_range(1, 12);
				end
			endcase
		end

		// Wait for the last characters, then give the encoder time to misbehave.
		quiet = 1'b1;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d messages; %0d lines and %0d characters checked.",
			items_sent, messages_sent, lines_predicted, chars_checked);
		$display("Included padded groups, exactly full lines, multi-line messages and stalls.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/uule_pkg.sv
src/uule_datapath.sv
src/uule_controller.sv
src/uuencode_line_encoder.sv
src/uule_checker.sv
tb/uule_checker.sv
tb/testbench.sv
